// ----- hdl/max_heap_delete_at_position_unit_defines.svh -----
// Assertion macros shared by the checker of the max-heap delete-at-position unit.
// The macros expect clk_i and rst_ni in the scope of the file that uses them.
`ifndef MAX_HEAP_DELETE_AT_POSITION_UNIT_DEFINES_SVH
`define MAX_HEAP_DELETE_AT_POSITION_UNIT_DEFINES_SVH

// Concurrent assertion that is switched off while reset is applied.
`define MHD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent assertion that also holds while reset is applied.
`define MHD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hdl/mhd_pkg.sv -----
// Shared types and constants of the max-heap delete-at-position unit.
// Has no dependencies; used by the top level and its checker.
package mhd_pkg;

  localparam int unsigned HEAP_DEPTH = 1024;
  localparam int unsigned CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned ADDR_W     = $clog2(HEAP_DEPTH);

  localparam logic [1:0] MODE_APPEND = 2'd0;
  localparam logic [1:0] MODE_BUILD  = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic        [1:0]       mode;
    logic signed [31:0]      value;
    logic        [CNT_W-1:0] position;
  } in_t;

  typedef struct packed {
    logic signed [31:0]      removed_value;
    logic        [1:0]       status;
    logic        [CNT_W-1:0] element_total;
  } out_t;

endpackage

// ----- hdl/max_heap_delete_at_position_unit.sv -----
// Max-heap store with append, build and delete-at-position transactions.
// Depends on mhd_pkg for the transaction types, store depth and codes.
//
// A transaction is taken when start is high and busy is low. Its result shows on res_o for
// exactly one cycle while result_valid_o is high, and the receiver cannot stall it; busy is
// low in that cycle, so the next transaction may be taken at once. Append, errors, a build
// of fewer than two elements and the unused mode give their result in the cycle after
// acceptance. All heap work runs through one single-port store with a registered read and
// one signed comparator, so every step waits on a store read: a delete reads the element at
// the position and the last element, then fills the hole with the last element and sifts it
// up or down level by level, and a build sinks each parent in turn, from the last parent
// down to the root.
module max_heap_delete_at_position_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  mhd_pkg::in_t in_i,
  output logic         result_valid_o,
  output mhd_pkg::out_t res_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BUILD_RD,
    S_BUILD_ITEM,
    S_DEL_RD,
    S_DEL_POS,
    S_DEL_LAST,
    S_DEL_DECIDE,
    S_SU_RD,
    S_SU_CMP,
    S_SD_LEFT,
    S_SD_RIGHT,
    S_SD_PICK,
    S_SD_CMP,
    S_DONE
  } state_e;

  localparam int unsigned CW = mhd_pkg::CNT_W;
  localparam int unsigned AW = mhd_pkg::ADDR_W;

  // Slots are one-based; the store is indexed from zero.
  function automatic logic [AW-1:0] slot2addr(input logic [CW-1:0] slot);
    logic [CW-1:0] t;
    t = slot - CW'(1);
    return t[AW-1:0];
  endfunction

  logic signed [31:0] mem [mhd_pkg::HEAP_DEPTH];
  logic signed [31:0] rdata_q;
  logic        [AW-1:0] rd_addr, wr_addr;
  logic signed [31:0] wr_data;
  logic               we;

  state_e             state_q, state_d;
  logic [1:0]         mode_q, mode_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      pos_q, pos_d;
  logic [CW-1:0]      h_q, h_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      cidx_q, cidx_d;
  logic signed [31:0] item_q, item_d;
  logic signed [31:0] child_q, child_d;
  logic signed [31:0] removed_q, removed_d;
  logic [1:0]         status_q, status_d;
  logic               valid_q, busy_q;

  logic               accept;
  logic               build_more;
  logic [CW:0]        left;

  assign accept     = start && !busy_q;
  assign build_more = (mode_q == mhd_pkg::MODE_BUILD) && (idx_q > CW'(1));
  assign left       = {h_q, 1'b0};

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    count_d   = count_q;
    pos_d     = pos_q;
    h_d       = h_q;
    idx_d     = idx_q;
    cidx_d    = cidx_q;
    item_d    = item_q;
    child_d   = child_q;
    removed_d = removed_q;
    status_d  = status_q;
    rd_addr   = '0;
    we        = 1'b0;
    wr_addr   = slot2addr(h_q);
    wr_data   = item_q;

    case (state_q)
      S_IDLE, S_DONE: begin
        state_d = S_IDLE;
        if (accept) begin
          mode_d    = in_i.mode;
          pos_d     = in_i.position;
          removed_d = '0;
          status_d  = mhd_pkg::ST_OK;
          state_d   = S_DONE;
          case (in_i.mode)
            mhd_pkg::MODE_APPEND: begin
              if (count_q >= CW'(mhd_pkg::HEAP_DEPTH)) begin
                status_d = mhd_pkg::ST_FULL;
              end else begin
                we      = 1'b1;
                wr_addr = count_q[AW-1:0];
                wr_data = in_i.value;
                count_d = count_q + CW'(1);
              end
            end
            mhd_pkg::MODE_BUILD: begin
              if ((count_q >> 1) != '0) begin
                idx_d   = count_q >> 1;
                state_d = S_BUILD_RD;
              end
            end
            mhd_pkg::MODE_DELETE: begin
              if (count_q == '0) begin
                status_d = mhd_pkg::ST_EMPTY;
              end else if (in_i.position == '0 || in_i.position > count_q) begin
                status_d = mhd_pkg::ST_BADPOS;
              end else begin
                state_d = S_DEL_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_BUILD_RD: begin
        rd_addr = slot2addr(idx_q);
        state_d = S_BUILD_ITEM;
      end
      S_BUILD_ITEM: begin
        item_d  = rdata_q;
        h_d     = idx_q;
        state_d = S_SD_LEFT;
      end
      S_DEL_RD: begin
        rd_addr = slot2addr(pos_q);
        state_d = S_DEL_POS;
      end
      S_DEL_POS: begin
        removed_d = rdata_q;
        rd_addr   = slot2addr(count_q);
        state_d   = S_DEL_LAST;
      end
      S_DEL_LAST: begin
        // The last element fills the hole; deleting the last slot moves nothing.
        item_d  = rdata_q;
        count_d = count_q - CW'(1);
        h_d     = pos_q;
        if (pos_q == count_q) begin
          state_d = S_DONE;
        end else if (pos_q == CW'(1)) begin
          state_d = S_SD_LEFT;
        end else begin
          rd_addr = slot2addr(pos_q >> 1);
          state_d = S_DEL_DECIDE;
        end
      end
      S_DEL_DECIDE: begin
        if (rdata_q < item_q) begin
          we      = 1'b1;
          wr_data = rdata_q;
          h_d     = h_q >> 1;
          state_d = S_SU_RD;
        end else begin
          state_d = S_SD_LEFT;
        end
      end
      S_SU_RD: begin
        if (h_q == CW'(1)) begin
          we      = 1'b1;
          state_d = S_DONE;
        end else begin
          rd_addr = slot2addr(h_q >> 1);
          state_d = S_SU_CMP;
        end
      end
      S_SU_CMP: begin
        we = 1'b1;
        if (rdata_q < item_q) begin
          wr_data = rdata_q;
          h_d     = h_q >> 1;
          state_d = S_SU_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SD_LEFT: begin
        if (left > {1'b0, count_q}) begin
          we = 1'b1;
          if (build_more) begin
            idx_d   = idx_q - CW'(1);
            state_d = S_BUILD_RD;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          rd_addr = slot2addr(left[CW-1:0]);
          state_d = S_SD_RIGHT;
        end
      end
      S_SD_RIGHT: begin
        child_d = rdata_q;
        cidx_d  = left[CW-1:0];
        if (left[CW-1:0] < count_q) begin
          rd_addr = slot2addr(left[CW-1:0] + CW'(1));
          state_d = S_SD_PICK;
        end else begin
          state_d = S_SD_CMP;
        end
      end
      S_SD_PICK: begin
        // On equal children the left one stays selected.
        if (child_q < rdata_q) begin
          child_d = rdata_q;
          cidx_d  = cidx_q + CW'(1);
        end
        state_d = S_SD_CMP;
      end
      S_SD_CMP: begin
        we = 1'b1;
        if (item_q < child_q) begin
          wr_data = child_q;
          h_d     = cidx_q;
          state_d = S_SD_LEFT;
        end else if (build_more) begin
          idx_d   = idx_q - CW'(1);
          state_d = S_BUILD_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= mhd_pkg::MODE_APPEND;
      count_q   <= '0;
      pos_q     <= '0;
      h_q       <= '0;
      idx_q     <= '0;
      cidx_q    <= '0;
      item_q    <= '0;
      child_q   <= '0;
      removed_q <= '0;
      status_q  <= mhd_pkg::ST_OK;
      valid_q   <= 1'b0;
      busy_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
      h_q       <= h_d;
      idx_q     <= idx_d;
      cidx_q    <= cidx_d;
      item_q    <= item_d;
      child_q   <= child_d;
      removed_q <= removed_d;
      status_q  <= status_d;
      valid_q   <= (state_d == S_DONE);
      busy_q    <= !(state_d == S_IDLE || state_d == S_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  assign busy           = busy_q;
  assign result_valid_o = valid_q;

  always_comb begin
    res_o.removed_value = removed_q;
    res_o.status        = status_q;
    res_o.element_total = count_q;
  end

endmodule

// ----- hdl/mhd_checker.sv -----
// Port-level checks of the max-heap delete-at-position unit, bound to its top level.
// Depends on mhd_pkg and on the assertion macros in the defines header.
`include "max_heap_delete_at_position_unit_defines.svh"

module mhd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          result_valid_o,
  input mhd_pkg::out_t res_o
);

  localparam int unsigned CW = mhd_pkg::CNT_W;

  logic accept;
  logic err_result;
  logic total_ok;

  assign accept     = start && !busy;
  assign err_result = result_valid_o && (res_o.status != mhd_pkg::ST_OK);
  assign total_ok   = res_o.element_total <= CW'(mhd_pkg::HEAP_DEPTH);

  // A taken transaction either starts heap work or gives its result next cycle.
  `MHD_ASSERT(a_accept_progress, accept |=> busy || result_valid_o, "accepted transaction stalled")

  // A result only shows once the heap work behind it is over.
  `MHD_ASSERT(a_result_not_busy, result_valid_o |-> !busy, "result shown while busy")

  // A second result in a row needs a new transaction taken in between.
  `MHD_ASSERT(a_one_result, result_valid_o |=> !result_valid_o || $past(accept), "result repeated")

  // Failed transactions remove nothing.
  `MHD_ASSERT(a_removed_zero, err_result |-> res_o.removed_value == 0, "removed value on error")

  // The element total never exceeds the store depth.
  `MHD_ASSERT_ALWAYS(a_total_range, !rst_ni || !result_valid_o || total_ok, "element total too large")

endmodule

bind max_heap_delete_at_position_unit mhd_checker u_mhd_checker (.*);
